[rtl/gcl_pkg.sv]
// shared widths and codes of the gcd / lcm unit
package gcl_pkg;

	localparam int OPCODE_W  = 1;
	localparam int OPERAND_W = 32;
	localparam int RESULT_W  = 32;
	localparam int STATUS_W  = 2;

	localparam logic [OPCODE_W-1:0] OP_GCD = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_LCM = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

[rtl/gcl_if.sv]
// request and response channel interfaces of the gcd / lcm unit
interface gcl_req_if;
	logic                               valid;
	logic                               ready;
	logic [gcl_pkg::OPCODE_W-1:0]       opcode;
	logic [gcl_pkg::OPERAND_W-1:0]      operand_a;
	logic [gcl_pkg::OPERAND_W-1:0]      operand_b;

	modport source (output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface

interface gcl_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [gcl_pkg::RESULT_W-1:0]       result;
	logic [gcl_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output result, output status, input ready);
	modport sink (input valid, input result, input status, output ready);
endinterface

[rtl/gcd_lcm_unit.sv]
// gcd / lcm unit: binary gcd, shift-subtract divide and shift-add multiply on one adder
//
// usage: a request beat on req carries opcode (gcd or lcm) and two unsigned operands,
// masked to WIDTH bits. one response beat on rsp carries the result and a status:
// ok, zero operand (result 0) or lcm overflow (result all ones of WIDTH bits).
// results are truncated to the 32-bit field.
// the unit works on one request at a time; req.ready is high only while idle.
// a zero operand goes straight to the final state and on to the response register.
// otherwise the binary gcd loop runs, then the shift back of the common factors of
// two; lcm then adds a division (a / gcd) and a multiplication (quotient * b). the
// gcd, division and multiplication loops share the single WIDTH+1 bit adder.
// the response sits in an output register; the unit takes the next request while
// an old response still waits, and holds the new result in its final state until
// the receiver has taken the old beat.
// reset clears the sequencer and the response valid; nothing else is needed.
module gcd_lcm_unit #(
	parameter int WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	gcl_req_if.sink   req,
	gcl_rsp_if.source rsp
);

	// widest of operand width and result field, for masking and extending
	localparam int EW = (WIDTH > gcl_pkg::RESULT_W) ? WIDTH : gcl_pkg::RESULT_W;
	localparam int CW = $clog2(WIDTH + 1);
	localparam int AW = WIDTH + 1;
	localparam logic [EW-1:0] SAT_EXT = EW'({WIDTH{1'b1}});

	typedef enum logic [2:0] {
		S_IDLE,
		S_GCD,
		S_SHL,
		S_DIV,
		S_MUL,
		S_FIN
	} state_t;

	state_t                        state_q;
	logic [gcl_pkg::OPCODE_W-1:0]  op_q;
	logic [WIDTH-1:0]              a_q;
	logic [WIDTH-1:0]              b_q;
	logic [WIDTH-1:0]              x_q;
	logic [WIDTH-1:0]              y_q;
	logic [CW-1:0]                 cnt_q;
	logic [WIDTH-1:0]              res_q;
	logic [gcl_pkg::STATUS_W-1:0]  st_q;
	logic                          ov_q;
	logic [gcl_pkg::RESULT_W-1:0]  out_res_q;
	logic [gcl_pkg::STATUS_W-1:0]  out_st_q;

	// operand masking to WIDTH bits
	logic [EW-1:0]    a_ext;
	logic [EW-1:0]    b_ext;
	logic [WIDTH-1:0] a_in;
	logic [WIDTH-1:0] b_in;
	logic [EW-1:0]    res_ext;

	assign a_ext   = EW'(req.operand_a);
	assign b_ext   = EW'(req.operand_b);
	assign a_in    = a_ext[WIDTH-1:0];
	assign b_in    = b_ext[WIDTH-1:0];
	assign res_ext = EW'(res_q);

	// the one shared adder: subtract for gcd and divide, add for multiply
	logic [AW-1:0] alu_a;
	logic [AW-1:0] alu_b;
	logic          alu_sub;
	logic [AW:0]   alu_res;
	logic          alu_ge;
	logic          x_gt;

	assign x_gt = (x_q > y_q);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		case (state_q)
			S_GCD: begin
				// larger minus smaller
				alu_a = {1'b0, (x_gt ? x_q : y_q)};
				alu_b = {1'b0, (x_gt ? y_q : x_q)};
			end
			S_DIV: begin
				// partial remainder with next dividend bit against the divisor
				alu_a = {y_q, a_q[WIDTH-1]};
				alu_b = {1'b0, x_q};
			end
			S_MUL: begin
				// high half of the product plus multiplicand
				alu_a   = {1'b0, y_q};
				alu_b   = {1'b0, b_q};
				alu_sub = 1'b0;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_res = {1'b0, alu_a} +
		(alu_sub ? ({1'b0, ~alu_b} + (AW + 1)'(1)) : {1'b0, alu_b});
	// on subtract, the top bit is set when no borrow, i.e. alu_a >= alu_b
	assign alu_ge  = alu_res[AW];

	// multiply step: conditional add then shift right of {hi, lo}
	logic [WIDTH:0]   mul_sum;
	logic [WIDTH-1:0] mul_hi;
	logic [WIDTH-1:0] mul_lo;

	assign mul_sum = a_q[0] ? alu_res[WIDTH:0] : {1'b0, y_q};
	assign mul_hi  = mul_sum[WIDTH:1];
	assign mul_lo  = {mul_sum[0], a_q[WIDTH-1:1]};

	// finished result moves into the response register when that is free
	logic fin_load;

	assign fin_load = (state_q == S_FIN) && (!ov_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= gcl_pkg::OP_GCD;
			a_q       <= '0;
			b_q       <= '0;
			x_q       <= '0;
			y_q       <= '0;
			cnt_q     <= '0;
			res_q     <= '0;
			st_q      <= gcl_pkg::STATUS_OK;
			ov_q      <= 1'b0;
			out_res_q <= '0;
			out_st_q  <= gcl_pkg::STATUS_OK;
		end else begin
			if (fin_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q  <= req.opcode;
						a_q   <= a_in;
						b_q   <= b_in;
						x_q   <= a_in;
						y_q   <= b_in;
						cnt_q <= '0;
						if (a_in == '0 || b_in == '0) begin
							res_q   <= '0;
							st_q    <= gcl_pkg::STATUS_ZERO;
							state_q <= S_FIN;
						end else begin
							state_q <= S_GCD;
						end
					end
				end
				S_GCD: begin
					// stein's algorithm, one step a cycle; cnt_q counts common twos
					if (x_q == y_q) begin
						state_q <= S_SHL;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q   <= x_q >> 1;
						y_q   <= y_q >> 1;
						cnt_q <= cnt_q + CW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_gt) begin
						x_q <= {1'b0, alu_res[WIDTH-1:1]};
					end else begin
						y_q <= {1'b0, alu_res[WIDTH-1:1]};
					end
				end
				S_SHL: begin
					// restore the common factor of two
					if (cnt_q != '0) begin
						x_q   <= x_q << 1;
						cnt_q <= cnt_q - CW'(1);
					end else if (op_q == gcl_pkg::OP_LCM) begin
						y_q     <= '0;
						cnt_q   <= CW'(WIDTH);
						state_q <= S_DIV;
					end else begin
						res_q   <= x_q;
						st_q    <= gcl_pkg::STATUS_OK;
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					// restoring division of a by gcd, quotient shifts into a_q
					a_q <= {a_q[WIDTH-2:0], alu_ge};
					if (cnt_q == CW'(1)) begin
						y_q     <= '0;
						cnt_q   <= CW'(WIDTH);
						state_q <= S_MUL;
					end else begin
						y_q   <= alu_ge ? alu_res[WIDTH-1:0] : alu_a[WIDTH-1:0];
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_MUL: begin
					y_q   <= mul_hi;
					a_q   <= mul_lo;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						if (mul_hi != '0) begin
							res_q <= '1;
							st_q  <= gcl_pkg::STATUS_OVERFLOW;
						end else begin
							res_q <= mul_lo;
							st_q  <= gcl_pkg::STATUS_OK;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// wait for the response register to be free
					if (fin_load) begin
						out_res_q <= res_ext[gcl_pkg::RESULT_W-1:0];
						out_st_q  <= st_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = ov_q;
	assign rsp.result = out_res_q;
	assign rsp.status = out_st_q;

	// an accepted request keeps the unit busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("unit ready right after accepting a request");

	// zero operand beat always carries a zero result
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == gcl_pkg::STATUS_ZERO |-> rsp.result == '0)
		else $error("zero operand status with nonzero result");

	// overflow beat carries the saturated value
	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == gcl_pkg::STATUS_OVERFLOW
		|-> rsp.result == SAT_EXT[gcl_pkg::RESULT_W-1:0])
		else $error("overflow status without saturated result");

	// gcd loop never works on a zero value
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GCD |-> x_q != '0 && y_q != '0)
		else $error("gcd loop reached a zero operand");

	// step counter stays within the operand width
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WIDTH))
		else $error("step counter beyond width");

endmodule
